// ----- sv/mcfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_pkg
// Shared widths, limit tables, reciprocal tables and lane control type for
// the impedance-mode command frame encoder.
// ----------------------------------------------------------------------------
package mcfe_pkg;

    localparam int DATA_W        = 32;
    localparam int FRACTION_BITS = 16;
    localparam int MOTOR_TYPES   = 12;
    localparam int TABLE_ROWS    = 12;
    localparam int TYPE_W        = 4;
    localparam int ID_W          = 11;
    localparam int BYTE_W        = 8;
    localparam int POS_BITS      = 16;
    localparam int LOW_BITS      = 12;
    localparam int CODE_W        = 16;
    localparam int DIV_W         = 10;
    localparam int RECIP_SHIFT   = 32;
    localparam int RECIP_W       = 32;
    localparam int LANE_STAGES   = 5;

    localparam int USED_ROWS = (MOTOR_TYPES < TABLE_ROWS) ? MOTOR_TYPES : TABLE_ROWS;
    localparam int ROW_MAX   = USED_ROWS - 1;
    localparam int ROW_W     = $clog2(TABLE_ROWS);

    // derived datapath widths
    localparam int SPAN_W  = DIV_W + FRACTION_BITS;
    localparam int CLAMP_W = ((DATA_W > SPAN_W) ? DATA_W : SPAN_W) + 2;
    localparam int PROD_W  = SPAN_W + CODE_W;
    localparam int NUM_W   = DIV_W + CODE_W;
    localparam int MUL_W   = NUM_W + RECIP_W;
    localparam int CHK_W   = NUM_W;

    localparam logic [CODE_W-1:0] POS_FULL = CODE_W'((64'd1 << POS_BITS) - 64'd1);
    localparam logic [CODE_W-1:0] LOW_FULL = CODE_W'((64'd1 << LOW_BITS) - 64'd1);

    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;

    // gain ranges in whole units
    localparam logic [DIV_W-1:0]   KP_DIV = DIV_W'(500);
    localparam logic [DIV_W-1:0]   KD_DIV = DIV_W'(5);
    localparam logic [RECIP_W-1:0] RCP_KP = RECIP_W'(RECIP_ONE / 500);
    localparam logic [RECIP_W-1:0] RCP_KD = RECIP_W'(RECIP_ONE / 5);

    // doubled per-type limits: full span in whole units
    localparam logic [DIV_W-1:0] LIM_POS2 [TABLE_ROWS] = '{
        DIV_W'(25), DIV_W'(25), DIV_W'(25), DIV_W'(25), DIV_W'(25), DIV_W'(25),
        DIV_W'(25), DIV_W'(25), DIV_W'(25), DIV_W'(25), DIV_W'(25), DIV_W'(25)
    };
    localparam logic [DIV_W-1:0] LIM_VEL2 [TABLE_ROWS] = '{
        DIV_W'(60), DIV_W'(100), DIV_W'(20), DIV_W'(20), DIV_W'(90), DIV_W'(90),
        DIV_W'(90), DIV_W'(50), DIV_W'(40), DIV_W'(560), DIV_W'(90), DIV_W'(90)
    };
    localparam logic [DIV_W-1:0] LIM_TRQ2 [TABLE_ROWS] = '{
        DIV_W'(20), DIV_W'(20), DIV_W'(56), DIV_W'(56), DIV_W'(24), DIV_W'(40),
        DIV_W'(108), DIV_W'(400), DIV_W'(400), DIV_W'(2), DIV_W'(20), DIV_W'(20)
    };

    localparam logic [RECIP_W-1:0] RCP_POS [TABLE_ROWS] = '{
        RECIP_W'(RECIP_ONE / 25), RECIP_W'(RECIP_ONE / 25), RECIP_W'(RECIP_ONE / 25),
        RECIP_W'(RECIP_ONE / 25), RECIP_W'(RECIP_ONE / 25), RECIP_W'(RECIP_ONE / 25),
        RECIP_W'(RECIP_ONE / 25), RECIP_W'(RECIP_ONE / 25), RECIP_W'(RECIP_ONE / 25),
        RECIP_W'(RECIP_ONE / 25), RECIP_W'(RECIP_ONE / 25), RECIP_W'(RECIP_ONE / 25)
    };
    localparam logic [RECIP_W-1:0] RCP_VEL [TABLE_ROWS] = '{
        RECIP_W'(RECIP_ONE / 60), RECIP_W'(RECIP_ONE / 100), RECIP_W'(RECIP_ONE / 20),
        RECIP_W'(RECIP_ONE / 20), RECIP_W'(RECIP_ONE / 90), RECIP_W'(RECIP_ONE / 90),
        RECIP_W'(RECIP_ONE / 90), RECIP_W'(RECIP_ONE / 50), RECIP_W'(RECIP_ONE / 40),
        RECIP_W'(RECIP_ONE / 560), RECIP_W'(RECIP_ONE / 90), RECIP_W'(RECIP_ONE / 90)
    };
    localparam logic [RECIP_W-1:0] RCP_TRQ [TABLE_ROWS] = '{
        RECIP_W'(RECIP_ONE / 20), RECIP_W'(RECIP_ONE / 20), RECIP_W'(RECIP_ONE / 56),
        RECIP_W'(RECIP_ONE / 56), RECIP_W'(RECIP_ONE / 24), RECIP_W'(RECIP_ONE / 40),
        RECIP_W'(RECIP_ONE / 108), RECIP_W'(RECIP_ONE / 400), RECIP_W'(RECIP_ONE / 400),
        RECIP_W'(RECIP_ONE / 2), RECIP_W'(RECIP_ONE / 20), RECIP_W'(RECIP_ONE / 20)
    };

    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
    } lane_ctl_t;

endpackage

// ----- sv/mcfe_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_lane
// One quantizer lane: clamp to range, scale by the code full scale, divide
// by the span through a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module mcfe_lane (
    input  logic                               aclk,
    input  mcfe_pkg::lane_ctl_t                ctl,
    input  logic signed [mcfe_pkg::DATA_W-1:0] x,
    input  logic [mcfe_pkg::DIV_W-1:0]         div,
    input  logic [mcfe_pkg::RECIP_W-1:0]       rcp,
    input  logic                               bipolar,
    input  logic [mcfe_pkg::CODE_W-1:0]        full,
    output logic [mcfe_pkg::CODE_W-1:0]        code
);

    logic signed [mcfe_pkg::DATA_W-1:0] x1_reg;
    logic [mcfe_pkg::DIV_W-1:0]         div1_reg, div2_reg, div3_reg, div4_reg, div5_reg;
    logic [mcfe_pkg::RECIP_W-1:0]       rcp1_reg, rcp2_reg, rcp3_reg;
    logic [mcfe_pkg::SPAN_W-1:0]        d_reg, d_next;
    logic [mcfe_pkg::NUM_W-1:0]         n3_reg, n4_reg, n5_reg;
    logic [mcfe_pkg::MUL_W-1:0]         m_reg;
    logic [mcfe_pkg::CODE_W-1:0]        q0_reg;
    logic [mcfe_pkg::CHK_W-1:0]         t_reg;

    logic [mcfe_pkg::SPAN_W-1:0]         span;
    logic signed [mcfe_pkg::CLAMP_W-1:0] xs, lo_s, hi_s, diff_s;
    logic [mcfe_pkg::PROD_W-1:0]         prod;
    logic [mcfe_pkg::CODE_W-1:0]         q0_w;
    logic [mcfe_pkg::NUM_W-1:0]          rem;

    // clamp and offset
    always_comb begin
        span   = {div1_reg, {mcfe_pkg::FRACTION_BITS{1'b0}}};
        xs     = mcfe_pkg::CLAMP_W'(x1_reg);
        lo_s   = bipolar ? -$signed(mcfe_pkg::CLAMP_W'(span >> 1)) : '0;
        hi_s   = lo_s + $signed(mcfe_pkg::CLAMP_W'(span));
        diff_s = xs - lo_s;
        if (xs < lo_s) begin
            d_next = '0;
        end else if (xs > hi_s) begin
            d_next = span;
        end else begin
            d_next = diff_s[mcfe_pkg::SPAN_W-1:0];
        end
    end

    assign prod = mcfe_pkg::PROD_W'(d_reg) * mcfe_pkg::PROD_W'(full);
    assign q0_w = m_reg[mcfe_pkg::RECIP_SHIFT +: mcfe_pkg::CODE_W];

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            x1_reg   <= x;
            div1_reg <= div;
            rcp1_reg <= rcp;
        end
        if (ctl.load[1]) begin
            d_reg    <= d_next;
            div2_reg <= div1_reg;
            rcp2_reg <= rcp1_reg;
        end
        if (ctl.load[2]) begin
            n3_reg   <= prod[mcfe_pkg::FRACTION_BITS +: mcfe_pkg::NUM_W];
            div3_reg <= div2_reg;
            rcp3_reg <= rcp2_reg;
        end
        if (ctl.load[3]) begin
            m_reg    <= mcfe_pkg::MUL_W'(n3_reg) * mcfe_pkg::MUL_W'(rcp3_reg);
            n4_reg   <= n3_reg;
            div4_reg <= div3_reg;
        end
        if (ctl.load[4]) begin
            q0_reg   <= q0_w;
            t_reg    <= mcfe_pkg::CHK_W'(q0_w) * mcfe_pkg::CHK_W'(div4_reg);
            n5_reg   <= n4_reg;
            div5_reg <= div4_reg;
        end
    end

    // quotient estimate is exact or one low
    assign rem  = n5_reg - mcfe_pkg::NUM_W'(t_reg);
    assign code = q0_reg + mcfe_pkg::CODE_W'(rem >= mcfe_pkg::NUM_W'(div5_reg));

endmodule

// ----- sv/mcfe_pack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfe_pack
// Merges the five lane codes into the eight frame bytes and holds the
// finished word in the output register.
// ----------------------------------------------------------------------------
module mcfe_pack (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mcfe_pkg::ID_W-1:0]         in_id,
    input  logic [mcfe_pkg::CODE_W-1:0]       pos_code,
    input  logic [mcfe_pkg::CODE_W-1:0]       vel_code,
    input  logic [mcfe_pkg::CODE_W-1:0]       kp_code,
    input  logic [mcfe_pkg::CODE_W-1:0]       kd_code,
    input  logic [mcfe_pkg::CODE_W-1:0]       trq_code,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mcfe_pkg::ID_W-1:0]         m_frame_id,
    output logic [mcfe_pkg::BYTE_W-1:0]       m_byte0,
    output logic [mcfe_pkg::BYTE_W-1:0]       m_byte1,
    output logic [mcfe_pkg::BYTE_W-1:0]       m_byte2,
    output logic [mcfe_pkg::BYTE_W-1:0]       m_byte3,
    output logic [mcfe_pkg::BYTE_W-1:0]       m_byte4,
    output logic [mcfe_pkg::BYTE_W-1:0]       m_byte5,
    output logic [mcfe_pkg::BYTE_W-1:0]       m_byte6,
    output logic [mcfe_pkg::BYTE_W-1:0]       m_byte7
);

    logic valid_reg;

    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            m_frame_id <= in_id;
            m_byte0    <= pos_code[15:8];
            m_byte1    <= pos_code[7:0];
            m_byte2    <= vel_code[11:4];
            m_byte3    <= {vel_code[3:0], kp_code[11:8]};
            m_byte4    <= kp_code[7:0];
            m_byte5    <= kd_code[11:4];
            m_byte6    <= {kd_code[3:0], trq_code[11:8]};
            m_byte7    <= trq_code[7:0];
        end
    end

endmodule

// ----- sv/mit_command_frame_encoder.sv -----
`timescale 1ns / 1ps
// an accepted input word passes the five lane stages and then the output register before the result word is valid
// throughput: one word per cycle while the output is not stalled; five lane stages plus the output register
// each hold a word and advance independently, so bubbles close under stall
// latency is set by the clamp, scale, reciprocal multiply and correction stages and the output register
// reset: synchronous active-low aresetn clears all stage valid bits
// ----------------------------------------------------------------------------
// mit_command_frame_encoder
// Clamps and quantizes the five command values in parallel lanes and packs
// the codes into an eight-byte command frame with its CAN id.
// ----------------------------------------------------------------------------
module mit_command_frame_encoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mcfe_pkg::TYPE_W-1:0]        s_model,
    input  logic [mcfe_pkg::ID_W-1:0]          s_can_id,
    input  logic signed [mcfe_pkg::DATA_W-1:0] s_kp,
    input  logic signed [mcfe_pkg::DATA_W-1:0] s_kd,
    input  logic signed [mcfe_pkg::DATA_W-1:0] s_pos,
    input  logic signed [mcfe_pkg::DATA_W-1:0] s_vel,
    input  logic signed [mcfe_pkg::DATA_W-1:0] s_torque,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mcfe_pkg::ID_W-1:0]          m_frame_id,
    output logic [mcfe_pkg::BYTE_W-1:0]        m_byte0,
    output logic [mcfe_pkg::BYTE_W-1:0]        m_byte1,
    output logic [mcfe_pkg::BYTE_W-1:0]        m_byte2,
    output logic [mcfe_pkg::BYTE_W-1:0]        m_byte3,
    output logic [mcfe_pkg::BYTE_W-1:0]        m_byte4,
    output logic [mcfe_pkg::BYTE_W-1:0]        m_byte5,
    output logic [mcfe_pkg::BYTE_W-1:0]        m_byte6,
    output logic [mcfe_pkg::BYTE_W-1:0]        m_byte7
);

    localparam int LAST = mcfe_pkg::LANE_STAGES - 1;

    logic [mcfe_pkg::LANE_STAGES-1:0] valid_reg, valid_next;
    logic [mcfe_pkg::ID_W-1:0]        id_reg [mcfe_pkg::LANE_STAGES];
    mcfe_pkg::lane_ctl_t              ctl;
    logic                             pack_ready;

    logic [mcfe_pkg::TYPE_W-1:0] type_sat;
    logic [mcfe_pkg::ROW_W-1:0]  row;

    logic [mcfe_pkg::CODE_W-1:0] pos_code, vel_code, kp_code, kd_code, trq_code;

    // unknown types fall back to the last usable row
    assign type_sat = (s_model >= mcfe_pkg::TYPE_W'(mcfe_pkg::USED_ROWS)) ?
                      mcfe_pkg::TYPE_W'(mcfe_pkg::ROW_MAX) : s_model;
    assign row      = type_sat[mcfe_pkg::ROW_W-1:0];

    // per-stage advance: a stage loads when it is empty or its successor moves
    always_comb begin
        ctl.load[LAST] = !valid_reg[LAST] || pack_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            ctl.load[k] = !valid_reg[k] || ctl.load[k+1];
        end
        valid_next = valid_reg;
        if (ctl.load[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (ctl.load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    assign s_ready = ctl.load[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            id_reg[0] <= s_can_id;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (ctl.load[k]) begin
                id_reg[k] <= id_reg[k-1];
            end
        end
    end

    mcfe_lane u_pos (
        .aclk    (aclk),
        .ctl     (ctl),
        .x       (s_pos),
        .div     (mcfe_pkg::LIM_POS2[row]),
        .rcp     (mcfe_pkg::RCP_POS[row]),
        .bipolar (1'b1),
        .full    (mcfe_pkg::POS_FULL),
        .code    (pos_code)
    );

    mcfe_lane u_vel (
        .aclk    (aclk),
        .ctl     (ctl),
        .x       (s_vel),
        .div     (mcfe_pkg::LIM_VEL2[row]),
        .rcp     (mcfe_pkg::RCP_VEL[row]),
        .bipolar (1'b1),
        .full    (mcfe_pkg::LOW_FULL),
        .code    (vel_code)
    );

    mcfe_lane u_trq (
        .aclk    (aclk),
        .ctl     (ctl),
        .x       (s_torque),
        .div     (mcfe_pkg::LIM_TRQ2[row]),
        .rcp     (mcfe_pkg::RCP_TRQ[row]),
        .bipolar (1'b1),
        .full    (mcfe_pkg::LOW_FULL),
        .code    (trq_code)
    );

    mcfe_lane u_kp (
        .aclk    (aclk),
        .ctl     (ctl),
        .x       (s_kp),
        .div     (mcfe_pkg::KP_DIV),
        .rcp     (mcfe_pkg::RCP_KP),
        .bipolar (1'b0),
        .full    (mcfe_pkg::LOW_FULL),
        .code    (kp_code)
    );

    mcfe_lane u_kd (
        .aclk    (aclk),
        .ctl     (ctl),
        .x       (s_kd),
        .div     (mcfe_pkg::KD_DIV),
        .rcp     (mcfe_pkg::RCP_KD),
        .bipolar (1'b0),
        .full    (mcfe_pkg::LOW_FULL),
        .code    (kd_code)
    );

    mcfe_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (valid_reg[LAST]),
        .in_ready   (pack_ready),
        .in_id      (id_reg[LAST]),
        .pos_code   (pos_code),
        .vel_code   (vel_code),
        .kp_code    (kp_code),
        .kd_code    (kd_code),
        .trq_code   (trq_code),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_frame_id (m_frame_id),
        .m_byte0    (m_byte0),
        .m_byte1    (m_byte1),
        .m_byte2    (m_byte2),
        .m_byte3    (m_byte3),
        .m_byte4    (m_byte4),
        .m_byte5    (m_byte5),
        .m_byte6    (m_byte6),
        .m_byte7    (m_byte7)
    );

endmodule
